FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent property checks for simulation; they expand to nothing when the
// code is taken to synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: always");

// cons must hold in the same cycle as ante
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/ole_pkg.sv
// ----------------------------------------------------------------------------
// Ordered list engine package
// Opcodes, status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ole_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int ITEM_WIDTH_DEF = 32;

  localparam int OPCODE_W = 3;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT     = 3'd0,
    OP_REPLACE    = 3'd1,
    OP_READ       = 3'd2,
    OP_REMOVE_POS = 3'd3,
    OP_REMOVE_VAL = 3'd4,
    OP_FIND       = 3'd5,
    OP_CLEAR      = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_PUT,
    S_TAKE,
    S_SEARCH,
    S_DOWN,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: design/ole_channels.sv
// ----------------------------------------------------------------------------
// Ordered list engine channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ole_req_if
  import ole_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [POS_W-1:0]    position;
  logic [VALUE_W-1:0]  item_value;

  modport source (output valid, output opcode, output position, output item_value,
                  input ready);
  modport sink   (input valid, input opcode, input position, input item_value,
                  output ready);
endinterface

interface ole_rsp_if
  import ole_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  item_out;
  logic                found;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  item_count;

  modport source (output valid, output item_out, output found, output status,
                  output item_count, input ready);
  modport sink   (input valid, input item_out, input found, input status,
                  input item_count, output ready);
endinterface

`default_nettype wire

FILE: design/ordered_list_engine_core.sv
// ----------------------------------------------------------------------------
// Ordered list engine
// Array list with insert, replace, read, remove, search and clear, walked
// one entry per cycle through a store with one read and one write port.
// ----------------------------------------------------------------------------
//  Port     | Dir | Handshake    | Payload
//  in_req   | in  | valid/ready  | opcode, position, item_value
//  out_rsp  | out | valid/ready  | item_out, found, status, item_count
//
//  Replace, clear, range errors and append go straight to the done state;
//  insert near the front, remove and search walk the list: the store has
//  one read and one write port, so shifts and searches move one entry a cycle.
//  Reset clears the count and the sequencer; store contents stay undefined
//  and need no clearing pass. A new request is taken once the sequencer is
//  back in idle; a finished result waits in the output register meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ordered_list_engine_core
  import ole_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ole_req_if.sink    in_req,
  ole_rsp_if.source  out_rsp
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [ITEM_WIDTH-1:0] val_r, val_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [ITEM_WIDTH-1:0] res_item_r, res_item_nxt;
  logic                  res_found_r, res_found_nxt;
  status_t               res_status_r, res_status_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]    out_item_r, out_item_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [COUNT_W-1:0]    out_count_r, out_count_nxt;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [ITEM_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [ITEM_WIDTH-1:0] mem_rdata;

  logic                  accept;
  logic                  out_free;
  op_t                   in_op;
  logic [CMPW-1:0]       in_pos_ext, cnt_ext;
  logic                  ins_range, list_full, pos_oob, list_empty, pos_at_end;
  logic [CW-1:0]         idx_p1, idx_m1, idx_m2, cnt_p1, cnt_m1;
  logic [CW:0]           idx_p2;
  logic                  walk_last, down_last, up_top, hit;

  ole_store #(
    .DEPTH (CAPACITY),
    .WIDTH (ITEM_WIDTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;
  assign in_op        = op_t'(in_req.opcode);

  assign in_pos_ext = CMPW'(in_req.position);
  assign cnt_ext    = CMPW'(count_r);
  assign ins_range  = in_pos_ext > cnt_ext;
  assign pos_oob    = in_pos_ext >= cnt_ext;
  assign pos_at_end = in_pos_ext == cnt_ext;
  assign list_full  = count_r == CW'(CAPACITY);
  assign list_empty = count_r == '0;

  // shared index unit
  assign idx_p1 = idx_r + CW'(1);
  assign idx_m1 = idx_r - CW'(1);
  assign idx_m2 = idx_r - CW'(2);
  assign idx_p2 = (CW+1)'(idx_r) + (CW+1)'(2);
  assign cnt_p1 = count_r + CW'(1);
  assign cnt_m1 = count_r - CW'(1);

  assign walk_last = idx_p1 >= count_r;
  assign down_last = idx_p2 >= (CW+1)'(count_r);
  assign up_top    = CMPW'(idx_m1) == CMPW'(pos_r);
  assign hit       = mem_rdata == val_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_INSERT: begin
              if (ins_range || list_full || pos_at_end) begin
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_UP;
              end
            end
            OP_READ: begin
              state_nxt = pos_oob ? S_DONE : S_TAKE;
            end
            OP_REMOVE_POS: begin
              state_nxt = (list_empty || pos_oob) ? S_DONE : S_TAKE;
            end
            OP_REMOVE_VAL, OP_FIND: begin
              state_nxt = list_empty ? S_DONE : S_SEARCH;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_UP: begin
        if (up_top) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        state_nxt = S_DONE;
      end
      S_TAKE: begin
        state_nxt = (op_r == OP_READ || walk_last) ? S_DONE : S_DOWN;
      end
      S_SEARCH: begin
        if (hit) begin
          state_nxt = (op_r == OP_FIND || walk_last) ? S_DONE : S_DOWN;
        end else if (walk_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DOWN: begin
        if (down_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // datapath and store control
  always_comb begin
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    res_item_nxt   = res_item_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_item_nxt   = out_item_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r[AW-1:0];
    mem_wdata      = mem_rdata;
    mem_raddr      = idx_p1[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt         = in_op;
          pos_nxt        = in_req.position;
          val_nxt        = ITEM_WIDTH'({32'd0, in_req.item_value});
          res_item_nxt   = '0;
          res_found_nxt  = 1'b0;
          res_status_nxt = ST_OK;
          unique case (in_op)
            OP_INSERT: begin
              if (ins_range) begin
                res_status_nxt = ST_RANGE;
              end else if (list_full) begin
                res_status_nxt = ST_FULL;
              end else if (pos_at_end) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(in_req.position);
                mem_wdata = ITEM_WIDTH'({32'd0, in_req.item_value});
                count_nxt = cnt_p1;
              end else begin
                idx_nxt   = count_r;
                mem_raddr = cnt_m1[AW-1:0];
              end
            end
            OP_REPLACE: begin
              if (pos_oob) begin
                res_status_nxt = ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(in_req.position);
                mem_wdata = ITEM_WIDTH'({32'd0, in_req.item_value});
              end
            end
            OP_READ, OP_REMOVE_POS: begin
              if (in_op == OP_REMOVE_POS && list_empty) begin
                res_status_nxt = ST_EMPTY;
              end else if (pos_oob) begin
                res_status_nxt = ST_RANGE;
              end else begin
                idx_nxt   = CW'(in_req.position);
                mem_raddr = AW'(in_req.position);
              end
            end
            OP_REMOVE_VAL, OP_FIND: begin
              idx_nxt   = '0;
              mem_raddr = '0;
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_UP: begin
        // move entry idx-1 up into idx, fetch the next one down
        mem_we    = 1'b1;
        mem_raddr = idx_m2[AW-1:0];
        idx_nxt   = idx_m1;
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(pos_r);
        mem_wdata = val_r;
        count_nxt = cnt_p1;
      end
      S_TAKE: begin
        res_item_nxt = mem_rdata;
        if (op_r == OP_REMOVE_POS && walk_last) begin
          count_nxt = cnt_m1;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          res_found_nxt = 1'b1;
          if (op_r == OP_REMOVE_VAL) begin
            res_item_nxt = mem_rdata;
            if (walk_last) begin
              count_nxt = cnt_m1;
            end
          end
        end else if (!walk_last) begin
          idx_nxt = idx_p1;
        end
      end
      S_DOWN: begin
        // move entry idx+1 down into idx
        mem_we = 1'b1;
        if (down_last) begin
          count_nxt = cnt_m1;
        end else begin
          idx_nxt   = idx_p1;
          mem_raddr = idx_p2[AW-1:0];
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_item_nxt   = VALUE_W'(res_item_r);
          out_found_nxt  = res_found_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = COUNT_W'(count_r);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    res_item_r   <= res_item_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    out_item_r   <= out_item_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.item_out   = out_item_r;
  assign out_rsp.found      = out_found_r;
  assign out_rsp.status     = out_status_r;
  assign out_rsp.item_count = out_count_r;

  `ASSERT_ALWAYS(a_count_cap, clk, rst_n, count_r <= CW'(CAPACITY))
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_r != S_IDLE)
  `ASSERT_IMPLY(a_rsp_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r == S_DONE))
  `ASSERT_IMPLY(a_down_in_list, clk, rst_n, state_r == S_DOWN, idx_p1 < count_r)

endmodule

`default_nettype wire

FILE: design/ole_store.sv
// ----------------------------------------------------------------------------
// Ordered list entry store
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ole_store
  import ole_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int WIDTH = ITEM_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
